// ----- sv/teq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the timed event queue.
// No dependencies; every other file of the block imports this package.
package teq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KIND_W        = 3;
   localparam int TIME_W        = 32;
   localparam int TAG_W         = 16;
   localparam int STATUS_W      = 3;
   localparam int CNT_W         = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD        = 3'd0,
      KIND_ADD_FUTURE = 3'd1,
      KIND_REMOVE_AT  = 3'd2,
      KIND_ADVANCE    = 3'd3,
      KIND_LIST_AT    = 3'd4,
      KIND_LIST_ALL   = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DUE     = 3'd0,
      STATUS_LISTED  = 3'd1,
      STATUS_ADDED   = 3'd2,
      STATUS_FULL    = 3'd3,
      STATUS_SKIPPED = 3'd4,
      STATUS_REMOVED = 3'd5
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] due_time;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [TIME_W-1:0] due_time;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  removed_count;
   } result_type;

endpackage

// ----- sv/teq_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the timed event queue: valid/ready plus one operation item.
// Depends on teq_pkg for field widths.
interface teq_req_if;
   import teq_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TIME_W-1:0] time_value;
   logic [TAG_W-1:0]  event_tag;

   modport source (output valid, kind, time_value, event_tag, input ready);
   modport sink   (input valid, kind, time_value, event_tag, output ready);
endinterface

// ----- sv/teq_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel of the timed event queue: valid/ready plus one result item.
// Depends on teq_pkg for field widths.
interface teq_rsp_if;
   import teq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TIME_W-1:0]   event_time;
   logic [TAG_W-1:0]    event_tag_res;
   logic [CNT_W-1:0]    removed_count;
   logic                last;

   modport source (output valid, status, event_time, event_tag_res, removed_count, last,
                   input ready);
   modport sink   (input valid, status, event_time, event_tag_res, removed_count, last,
                   output ready);
endinterface

// ----- sv/teq_store.sv -----
`timescale 1ns / 1ps
// Event storage: one write port, one read port with registered read data.
// Depends on teq_pkg for the entry type.
module teq_store #(
   parameter  int DEPTH = teq_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  teq_pkg::entry_type  wr_entry,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output teq_pkg::entry_type  rd_entry
);
   import teq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ----- sv/timed_event_queue_core.sv -----
`timescale 1ns / 1ps
// Timed event queue: top level with the sequencer, compare unit and output stage.
// Depends on teq_pkg, teq_req_if, teq_rsp_if and teq_store.
//
// Usage
//   req_chan carries one operation per item: add, add if future, remove at,
//   advance, list at, list all. rsp_chan returns the results; last marks the
//   final result of an operation. Advance with nothing due and lists with no
//   match return nothing. Kinds 6 and 7 are ignored.
//   Events sit sorted by due time in a DEPTH-entry memory; ties keep arrival order.
// Timing
//   One item at a time: req ready is high only while the sequencer is idle.
//   Remove, advance and list walk every stored event, an add only those later
//   than its new time, through the single memory read port, one event per
//   cycle while no result is held up, through one shared compare unit. A
//   full or skipped add, or an add to an empty queue, needs no walk.
// Reset
//   Synchronous, active high: queue empty, current time zero, no result held.
//   The memory is not cleared; only slots below the event count are read.
// Stall
//   Results go out through a one-entry output register backed by a one-entry
//   pending stage. When the receiver stalls, the scan holds in place until the
//   output register frees; nothing is dropped.
module timed_event_queue_core #(
   parameter int DEPTH = teq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   teq_req_if.sink     req_chan,
   teq_rsp_if.source   rsp_chan
);
   import teq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_PUT,
      S_FIN
   } state_type;

   typedef struct packed {
      result_type res;
      logic       last;
   } rsp_type;

   state_type         state_ff,     state_in;
   kind_type          kind_ff,      kind_in;
   logic [TIME_W-1:0] key_ff,       key_in;
   logic [TAG_W-1:0]  tag_ff,       tag_in;
   logic [TIME_W-1:0] cur_time_ff,  cur_time_in;
   logic [CW-1:0]     count_ff,     count_in;
   logic [CW-1:0]     idx_ff,       idx_in;    // scan index, or insert slot
   logic [CW-1:0]     wr_ff,        wr_in;     // compaction write index
   logic              drop_ff,      drop_in;   // still in the due prefix
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff,      pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,       rsp_in;

   // memory port
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   entry_type         mem_wr_entry;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   entry_type         rd_entry;

   // shared compare unit
   logic [TIME_W-1:0] cmp_a, cmp_b;
   logic              cmp_le, cmp_eq;

   logic              out_free;
   logic              is_insert, emit, keep, stall, last_elem;
   logic [CW-1:0]     idx_inc, idx_dec, idx_dec2, count_dec, wr_next;
   entry_type         new_entry;

   teq_store #(.DEPTH(DEPTH)) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_entry (rd_entry)
   );

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign is_insert = (kind_ff == KIND_ADD) || (kind_ff == KIND_ADD_FUTURE);
   assign idx_inc   = idx_ff + CW'(1);
   assign idx_dec   = idx_ff - CW'(1);
   assign idx_dec2  = idx_ff - CW'(2);
   assign count_dec = count_ff - CW'(1);
   assign last_elem = (idx_ff == count_dec);
   assign new_entry = '{due_time: key_ff, tag: tag_ff};

   // In START the unit checks "add if future"; in SCAN it checks the stored event.
   always_comb begin
      if (state_ff == S_START) begin
         cmp_a = key_ff;
         cmp_b = cur_time_ff;
      end else begin
         cmp_a = rd_entry.due_time;
         cmp_b = (kind_ff == KIND_ADVANCE) ? cur_time_ff : key_ff;
      end
   end

   assign cmp_le = (cmp_a <= cmp_b);
   assign cmp_eq = (cmp_a == cmp_b);

   // scan decisions for remove, advance and list
   assign emit  = ((kind_ff == KIND_LIST_ALL) || ((kind_ff == KIND_LIST_AT) && cmp_eq)) ||
                  ((kind_ff == KIND_ADVANCE) && drop_ff && cmp_le);
   assign keep  = ((kind_ff == KIND_REMOVE_AT) && !cmp_eq) ||
                  ((kind_ff == KIND_ADVANCE) && !(drop_ff && cmp_le));
   assign stall = emit && pend_valid_ff && !out_free;
   assign wr_next = keep ? (wr_ff + CW'(1)) : wr_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      cur_time_in   = cur_time_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[AW-1:0];
      mem_wr_entry  = rd_entry;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in  = kind_type'(req_chan.kind);
               key_in   = req_chan.time_value;
               tag_in   = req_chan.event_tag;
               state_in = S_START;
            end
         end

         S_START: begin
            idx_in  = '0;
            wr_in   = '0;
            drop_in = 1'b1;
            unique case (kind_ff)
               KIND_ADD, KIND_ADD_FUTURE: begin
                  if ((kind_ff == KIND_ADD_FUTURE) && cmp_le) begin
                     pend_valid_in = 1'b1;
                     pend_in = '{status: STATUS_SKIPPED, due_time: key_ff, tag: tag_ff,
                                 removed_count: '0};
                     state_in = S_FIN;
                  end else if (count_ff == CW'(DEPTH)) begin
                     pend_valid_in = 1'b1;
                     pend_in = '{status: STATUS_FULL, due_time: key_ff, tag: tag_ff,
                                 removed_count: '0};
                     state_in = S_FIN;
                  end else if (count_ff == '0) begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = '0;
                     mem_wr_entry  = new_entry;
                     count_in      = CW'(1);
                     pend_valid_in = 1'b1;
                     pend_in = '{status: STATUS_ADDED, due_time: key_ff, tag: tag_ff,
                                 removed_count: '0};
                     state_in = S_FIN;
                  end else begin
                     // walk down from the tail, shifting later events up one slot
                     idx_in      = count_ff;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = count_dec[AW-1:0];
                     state_in    = S_SCAN;
                  end
               end
               KIND_REMOVE_AT, KIND_ADVANCE, KIND_LIST_AT, KIND_LIST_ALL: begin
                  if (kind_ff == KIND_ADVANCE) begin
                     cur_time_in = cur_time_ff + key_ff;
                  end
                  if (count_ff == '0) begin
                     if (kind_ff == KIND_REMOVE_AT) begin
                        pend_valid_in = 1'b1;
                        pend_in = '{status: STATUS_REMOVED, due_time: key_ff, tag: '0,
                                    removed_count: '0};
                     end
                     state_in = S_FIN;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SCAN: begin
            if (is_insert) begin
               if (!cmp_le) begin
                  // stored event is later: move it up into the slot above
                  mem_wr_en    = 1'b1;
                  mem_wr_addr  = idx_ff[AW-1:0];
                  mem_wr_entry = rd_entry;
                  if (idx_ff == CW'(1)) begin
                     idx_in   = '0;
                     state_in = S_PUT;
                  end else begin
                     idx_in      = idx_dec;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_dec2[AW-1:0];
                  end
               end else begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = idx_ff[AW-1:0];
                  mem_wr_entry  = new_entry;
                  count_in      = count_ff + CW'(1);
                  pend_valid_in = 1'b1;
                  pend_in = '{status: STATUS_ADDED, due_time: key_ff, tag: tag_ff,
                              removed_count: '0};
                  state_in = S_FIN;
               end
            end else if (!stall) begin
               if (emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{res: pend_ff, last: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_in = '{status: (kind_ff == KIND_ADVANCE) ? STATUS_DUE : STATUS_LISTED,
                              due_time: rd_entry.due_time, tag: rd_entry.tag,
                              removed_count: '0};
               end
               if (keep) begin
                  mem_wr_en    = 1'b1;
                  mem_wr_addr  = wr_ff[AW-1:0];
                  mem_wr_entry = rd_entry;
               end
               wr_in   = wr_next;
               drop_in = drop_ff && cmp_le;
               if (last_elem) begin
                  if (kind_ff == KIND_REMOVE_AT) begin
                     count_in      = wr_next;
                     pend_valid_in = 1'b1;
                     pend_in = '{status: STATUS_REMOVED, due_time: key_ff, tag: '0,
                                 removed_count: CNT_W'(count_ff - wr_next)};
                  end else if (kind_ff == KIND_ADVANCE) begin
                     count_in = wr_next;
                  end
                  state_in = S_FIN;
               end else begin
                  idx_in      = idx_inc;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_inc[AW-1:0];
               end
            end
         end

         S_PUT: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = '0;
            mem_wr_entry  = new_entry;
            count_in      = count_ff + CW'(1);
            pend_valid_in = 1'b1;
            pend_in = '{status: STATUS_ADDED, due_time: key_ff, tag: tag_ff,
                        removed_count: '0};
            state_in = S_FIN;
         end

         S_FIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '{res: pend_ff, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_time_ff   <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_time_ff   <= cur_time_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      key_ff  <= key_in;
      tag_ff  <= tag_in;
      idx_ff  <= idx_in;
      wr_ff   <= wr_in;
      drop_ff <= drop_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.res.status;
   assign rsp_chan.event_time    = rsp_ff.res.due_time;
   assign rsp_chan.event_tag_res = rsp_ff.res.tag;
   assign rsp_chan.removed_count = rsp_ff.res.removed_count;
   assign rsp_chan.last          = rsp_ff.last;

endmodule

// ----- sv/teq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the timed event queue, bound to the top level.
// Depends on teq_pkg and timed_event_queue_core.
module teq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [teq_pkg::STATUS_W-1:0] rsp_status,
   input logic [teq_pkg::TIME_W-1:0]   rsp_event_time,
   input logic [teq_pkg::TAG_W-1:0]    rsp_event_tag_res,
   input logic [teq_pkg::CNT_W-1:0]    rsp_removed_count,
   input logic                         rsp_last
);
   import teq_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_event_time, rsp_event_tag_res, rsp_removed_count, rsp_last}))
      else $error("result changed while stalled");

   // count only rides on a removal result
   a_count_only_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_REMOVED) |-> (rsp_removed_count == '0))
      else $error("removed_count set on a non-removal result");

   // single-result operations always close the item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_ADDED) || (rsp_status == STATUS_FULL) ||
                    (rsp_status == STATUS_SKIPPED) || (rsp_status == STATUS_REMOVED))
      |-> rsp_last)
      else $error("single result without last");

   // reset leaves an empty, ready block
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind timed_event_queue_core teq_checker u_teq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_event_time    (rsp_chan.event_time),
   .rsp_event_tag_res (rsp_chan.event_tag_res),
   .rsp_removed_count (rsp_chan.removed_count),
   .rsp_last          (rsp_chan.last)
);
